// ===== sv/awsf_pkg.sv =====
// shared types and constants for the 16-bit alu with status flags
`default_nettype none

package awsf_pkg;

    localparam int unsigned DATA_W     = 16;
    localparam int unsigned OP_W       = 4;
    localparam int unsigned FLAG_W     = 4;
    localparam int unsigned SHAMT_W    = $clog2(DATA_W) + 1;
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STAGES = DATA_W / DIV_STEPS;
    localparam int unsigned PIPE_LAST  = DIV_STAGES + 2;

    localparam int unsigned FLAG_Z = 0;
    localparam int unsigned FLAG_O = 1;
    localparam int unsigned FLAG_C = 2;
    localparam int unsigned FLAG_N = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_CMP  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_XOR  = 4'd7,
        OP_TEST = 4'd8,
        OP_SHL  = 4'd9,
        OP_SHR  = 4'd10,
        OP_NOT  = 4'd11,
        OP_XCHG = 4'd12
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] source_value;
        logic [FLAG_W-1:0] flags_in;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] dest_out;
        logic [DATA_W-1:0] source_out;
        logic [FLAG_W-1:0] flags_out;
        logic              divide_by_zero;
    } t_out;

    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
    } t_div;

endpackage

`default_nettype wire

// ===== sv/alu_with_status_flags_core.sv =====
// top level of the pipelined 16-bit alu with z/o/c/n flags
// throughput: one request per cycle unless stalled; every opcode takes the same path
// through the pipeline; signed divide runs as four stages of four steps
// each stage loads when empty or when its successor moves, so bubbles collapse under stall
// reset clears all stage valid bits together; payload registers are not reset
`default_nettype none

module alu_with_status_flags_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  awsf_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output awsf_pkg::t_out  o_out
);

    localparam int unsigned LAST = awsf_pkg::PIPE_LAST;
    localparam int unsigned DW   = awsf_pkg::DATA_W;

    logic [LAST:0]   r_vld;
    logic [LAST:0]   w_load;
    awsf_pkg::t_in   r_in;
    awsf_pkg::t_out  r_res [1:LAST];
    awsf_pkg::t_div  r_div [1:LAST-1];
    awsf_pkg::t_div  w_div [2:LAST-1];
    awsf_pkg::t_out  n_res1;
    awsf_pkg::t_div  n_div1;
    awsf_pkg::t_out  n_res_last;

    always_comb begin
        w_load[LAST] = !r_vld[LAST] || !i_out_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    assign o_in_stall  = !w_load[0];
    assign o_out_valid = r_vld[LAST];
    assign o_out       = r_res[LAST];

    // decode, combinational ops, flags and divider setup
    always_comb begin
        logic [DW-1:0]               d;
        logic [DW-1:0]               s;
        logic [DW-1:0]               r;
        logic [DW-1:0]               dout;
        logic [DW-1:0]               sout;
        logic [awsf_pkg::FLAG_W-1:0] f;
        logic [2*DW-1:0]             wide;
        logic                        dbz;
        d    = r_in.dest_value;
        s    = r_in.source_value;
        f    = r_in.flags_in;
        dout = d;
        sout = s;
        dbz  = 1'b0;
        r    = d - s;
        wide = '0;
        case (awsf_pkg::t_op'(r_in.opcode))
            awsf_pkg::OP_ADD: dout = d + s;
            awsf_pkg::OP_SUB: dout = r;
            awsf_pkg::OP_MUL: dout = d * s;
            awsf_pkg::OP_DIV: dbz = (s == '0);
            awsf_pkg::OP_CMP: begin
                f[awsf_pkg::FLAG_Z] = (r == '0);
                f[awsf_pkg::FLAG_N] = r[DW-1];
                f[awsf_pkg::FLAG_C] = (d < s);
                f[awsf_pkg::FLAG_O] = (d[DW-1] ^ s[DW-1]) & (d[DW-1] ^ r[DW-1]);
            end
            awsf_pkg::OP_AND: dout = d & s;
            awsf_pkg::OP_OR:  dout = d | s;
            awsf_pkg::OP_XOR: dout = d ^ s;
            awsf_pkg::OP_TEST: begin
                f[awsf_pkg::FLAG_Z] = ((d & s) == '0);
                f[awsf_pkg::FLAG_N] = d[DW-1] & s[DW-1];
            end
            awsf_pkg::OP_SHL: begin
                wide = {{DW{1'b0}}, d} << s[awsf_pkg::SHAMT_W-1:0];
                if (s > DW'(DW)) begin
                    dout                = '0;
                    f[awsf_pkg::FLAG_C] = 1'b0;
                end else begin
                    dout                = wide[DW-1:0];
                    f[awsf_pkg::FLAG_C] = wide[DW];
                end
                f[awsf_pkg::FLAG_Z] = (dout == '0);
                f[awsf_pkg::FLAG_N] = dout[DW-1];
            end
            awsf_pkg::OP_SHR: begin
                wide = {d, {DW{1'b0}}} >> s[awsf_pkg::SHAMT_W-1:0];
                if (s > DW'(DW)) begin
                    dout                = '0;
                    f[awsf_pkg::FLAG_C] = d[DW-1];
                end else begin
                    dout                = wide[2*DW-1:DW];
                    f[awsf_pkg::FLAG_C] = wide[DW-1];
                end
                f[awsf_pkg::FLAG_Z] = (dout == '0);
                f[awsf_pkg::FLAG_N] = dout[DW-1];
            end
            awsf_pkg::OP_NOT: dout = ~d;
            awsf_pkg::OP_XCHG: begin
                dout = s;
                sout = d;
            end
            default: ;
        endcase
        n_res1.dest_out       = dout;
        n_res1.source_out     = sout;
        n_res1.flags_out      = f;
        n_res1.divide_by_zero = dbz;
        n_div1.is_div = (awsf_pkg::t_op'(r_in.opcode) == awsf_pkg::OP_DIV) && (s != '0);
        n_div1.neg    = d[DW-1] ^ s[DW-1];
        n_div1.rem    = '0;
        n_div1.quo    = d[DW-1] ? -d : d;
        n_div1.dvs    = s[DW-1] ? -s : s;
    end

    for (genvar g = 2; g < LAST; g++) begin : g_div
        awsf_div_stage u_div_stage (
            .i_div (r_div[g-1]),
            .o_div (w_div[g])
        );
    end

    // quotient sign fix and result select
    always_comb begin
        n_res_last = r_res[LAST-1];
        if (r_div[LAST-1].is_div) begin
            n_res_last.dest_out = r_div[LAST-1].neg ? -r_div[LAST-1].quo
                                                    : r_div[LAST-1].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0] && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_load[1] && r_vld[0]) begin
            r_res[1] <= n_res1;
            r_div[1] <= n_div1;
        end
        for (int k = 2; k < LAST; k++) begin
            if (w_load[k] && r_vld[k-1]) begin
                r_res[k] <= r_res[k-1];
                r_div[k] <= w_div[k];
            end
        end
        if (w_load[LAST] && r_vld[LAST-1]) begin
            r_res[LAST] <= n_res_last;
        end
    end

endmodule

`default_nettype wire

// ===== sv/awsf_div_stage.sv =====
// four restoring division steps on magnitudes
`default_nettype none

module awsf_div_stage (
    input  awsf_pkg::t_div i_div,
    output awsf_pkg::t_div o_div
);

    always_comb begin
        logic [awsf_pkg::DATA_W+1:0] diff;
        awsf_pkg::t_div              cur;
        cur = i_div;
        for (int k = 0; k < awsf_pkg::DIV_STEPS; k++) begin
            diff = {1'b0, cur.rem, cur.quo[awsf_pkg::DATA_W-1]} - {2'b00, cur.dvs};
            if (!diff[awsf_pkg::DATA_W+1]) begin
                cur.rem = diff[awsf_pkg::DATA_W-1:0];
                cur.quo = {cur.quo[awsf_pkg::DATA_W-2:0], 1'b1};
            end else begin
                cur.rem = {cur.rem[awsf_pkg::DATA_W-2:0], cur.quo[awsf_pkg::DATA_W-1]};
                cur.quo = {cur.quo[awsf_pkg::DATA_W-2:0], 1'b0};
            end
        end
        o_div = cur;
    end

endmodule

`default_nettype wire

// ===== sv/awsf_checker.sv =====
// port-level checks for the alu core and their bind
`default_nettype none

module awsf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input awsf_pkg::t_out o_out
);

    // result held while the consumer stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a free output side never backs up the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("request stalled with output free");

    // input stall only when a result waits at a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled without a waiting result");

endmodule

bind alu_with_status_flags_core awsf_checker u_awsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
